// ----- hw/rtl/mlfq_pkg.sv -----
// Shared constants, command and status codes, FSM and datapath op types
// for the multilevel feedback-queue scheduler. No dependencies.
`default_nettype none

package mlfq_pkg;

    // Sizing
    localparam int MAX_PROCS  = 64;
    localparam int NUM_LEVELS = 4;
    localparam int LAST_LEVEL = NUM_LEVELS - 1;
    localparam int PID_W      = 6;
    localparam int LVL_W      = 2;
    localparam int IDX_W      = 7;
    localparam int SLC_W      = 4;
    localparam int CHN_W      = 8;
    localparam int CMD_W      = 3;
    localparam int STS_W      = 2;
    localparam int WOKEN_W    = 7;
    localparam int QADDR_W    = LVL_W + PID_W;
    localparam int Q_DEPTH    = NUM_LEVELS * MAX_PROCS;
    localparam int DEEP_LIMIT = 8;
    localparam int CFG_AW     = 4;
    localparam int CFG_DW     = 32;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PICK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADMIT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SLEEP = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WAKE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_EXIT  = 3'd4;

    // Result status codes
    localparam logic [STS_W-1:0] STS_OK      = 2'd0;
    localparam logic [STS_W-1:0] STS_IDLE    = 2'd1;
    localparam logic [STS_W-1:0] STS_FULL    = 2'd2;
    localparam logic [STS_W-1:0] STS_UNKNOWN = 2'd3;

    // Register indexes and reset values
    localparam logic [1:0] CFG_LIMIT0 = 2'd0;
    localparam logic [1:0] CFG_LIMIT1 = 2'd1;
    localparam logic [1:0] CFG_LIMIT2 = 2'd2;
    localparam logic [SLC_W-1:0] LIMIT0_RST = 4'd1;
    localparam logic [SLC_W-1:0] LIMIT1_RST = 4'd2;
    localparam logic [SLC_W-1:0] LIMIT2_RST = 4'd4;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_SW_TEST, S_SW_ID, S_SW_CNT,
        S_RM_ADJ, S_RM_RD, S_RM_WR, S_APPEND, S_EX_LVL,
        S_FD_RD, S_FD_CHK, S_WK_RD, S_WK_CHK,
        S_MF_RM, S_MF_INS, S_MF_RD, S_MF_WR, S_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LATCH, OP_RES_IDLE, OP_RES_FULL, OP_RES_UNKNOWN,
        OP_ADMIT, OP_SLEEP, OP_EXIT_START, OP_EX_LVL,
        OP_SW_NEXT, OP_SW_READ, OP_SW_SKIP, OP_GRANT_RD,
        OP_GRANT_KEEP, OP_GRANT_DEMOTE, OP_GRANT_ROTATE,
        OP_RM_ADJ, OP_RM_READ, OP_RM_WRITE, OP_APPEND,
        OP_FD_READ, OP_FD_MISS, OP_WK_READ, OP_WK_NEXT, OP_WK_HIT,
        OP_INS_ADJ, OP_MF_READ, OP_MF_WRITE, OP_MF_PUT, OP_OUT_LOAD
    } dp_op_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic any_run;
        logic pid_used;
        logic fill0_full;
        logic sw_end;
        logic sw_last;
        logic q_run;
        logic demote;
        logic idx_end;
        logic idx_zero;
        logic q_match;
        logic scan_end;
        logic wk_match;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mlfq_process_scheduler_unit.sv -----
// Top level of the multilevel feedback-queue scheduler: streaming ports,
// slice-limit registers, controller and datapath. Uses mlfq_pkg, mlfq_ctrl, mlfq_dp.
//
//  channel   dir  word                                            handshake
//  s_        in   cmd, proc_id, wait_channel                      tvalid/tready
//  m_        out  status, granted_id, granted_level, slice_count, tvalid/tready
//                 demoted, woken_count
//  apb       in   slice_limit_level0..2 at byte 0x0, 0x4, 0x8     psel/penable
//
// One word at a time. Pick passes over queue entries and steps level by level, and on a
// demote or rotate shifts the entries behind the granted one, all on the single read
// port of the queue RAM. Wake scans all 64 slots and, per woken process, searches its
// level (match included) and shifts entries to put it at the front. Exit searches its
// level (match included) and shifts the entries behind the match. Reset is synchronous,
// no clearing pass; a finished word waits in the output register while the next word is
// accepted.
`default_nettype none

module mlfq_process_scheduler_unit (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    // [2:0] cmd, [8:3] proc_id, [16:9] wait_channel, [23:17] zero
    input  wire  [23:0]                        s_tdata,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // [1:0] status, [7:2] granted_id, [9:8] granted_level, [13:10] slice_count,
    // [14] demoted, [21:15] woken_count, [23:22] zero
    output logic [23:0]                        m_tdata,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [mlfq_pkg::CFG_AW-1:0]        paddr,
    input  wire  [mlfq_pkg::CFG_DW-1:0]        pwdata,
    output logic [mlfq_pkg::CFG_DW-1:0]        prdata,
    output logic                               pready
);

    localparam int SW = mlfq_pkg::SLC_W;

    logic [SW-1:0] lim0_reg, lim1_reg, lim2_reg;
    logic          cfg_wr;
    logic [SW-1:0] rd_val;

    mlfq_pkg::dp_op_t   op;
    mlfq_pkg::dp_stat_t stat;

    logic [mlfq_pkg::STS_W-1:0]   o_status;
    logic [mlfq_pkg::PID_W-1:0]   o_id;
    logic [mlfq_pkg::LVL_W-1:0]   o_level;
    logic [SW-1:0]                o_count;
    logic                         o_demoted;
    logic [mlfq_pkg::WOKEN_W-1:0] o_woken;

    // Slice-limit registers
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim0_reg <= mlfq_pkg::LIMIT0_RST;
            lim1_reg <= mlfq_pkg::LIMIT1_RST;
            lim2_reg <= mlfq_pkg::LIMIT2_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                mlfq_pkg::CFG_LIMIT0: lim0_reg <= pwdata[SW-1:0];
                mlfq_pkg::CFG_LIMIT1: lim1_reg <= pwdata[SW-1:0];
                mlfq_pkg::CFG_LIMIT2: lim2_reg <= pwdata[SW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back
    always_comb begin
        case (paddr[3:2])
            mlfq_pkg::CFG_LIMIT0: rd_val = lim0_reg;
            mlfq_pkg::CFG_LIMIT1: rd_val = lim1_reg;
            mlfq_pkg::CFG_LIMIT2: rd_val = lim2_reg;
            default:              rd_val = '0;
        endcase
        prdata = {{(mlfq_pkg::CFG_DW - SW){1'b0}}, rd_val};
    end

    mlfq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .op       (op)
    );

    mlfq_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .op          (op),
        .in_cmd      (s_tdata[2:0]),
        .in_pid      (s_tdata[8:3]),
        .in_tag      (s_tdata[16:9]),
        .lim0        (lim0_reg),
        .lim1        (lim1_reg),
        .lim2        (lim2_reg),
        .stat        (stat),
        .out_status  (o_status),
        .out_id      (o_id),
        .out_level   (o_level),
        .out_count   (o_count),
        .out_demoted (o_demoted),
        .out_woken   (o_woken)
    );

    // Pack the result word
    assign m_tdata = {2'b00, o_woken, o_demoted, o_count, o_level, o_id, o_status};

endmodule

`default_nettype wire

// ----- hw/rtl/mlfq_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] waddr,
    input  wire  [WIDTH-1:0]         wdata,
    input  wire  [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/mlfq_dp.sv -----
// Scheduler datapath: queue and process tables, fill counts, sweep state,
// result registers. Driven one op per cycle. Uses mlfq_pkg and mlfq_ram.
`default_nettype none

module mlfq_dp (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  mlfq_pkg::dp_op_t             op,
    input  wire  [mlfq_pkg::CMD_W-1:0]   in_cmd,
    input  wire  [mlfq_pkg::PID_W-1:0]   in_pid,
    input  wire  [mlfq_pkg::CHN_W-1:0]   in_tag,
    input  wire  [mlfq_pkg::SLC_W-1:0]   lim0,
    input  wire  [mlfq_pkg::SLC_W-1:0]   lim1,
    input  wire  [mlfq_pkg::SLC_W-1:0]   lim2,
    output mlfq_pkg::dp_stat_t           stat,
    output logic [mlfq_pkg::STS_W-1:0]   out_status,
    output logic [mlfq_pkg::PID_W-1:0]   out_id,
    output logic [mlfq_pkg::LVL_W-1:0]   out_level,
    output logic [mlfq_pkg::SLC_W-1:0]   out_count,
    output logic                         out_demoted,
    output logic [mlfq_pkg::WOKEN_W-1:0] out_woken
);

    localparam int NP = mlfq_pkg::MAX_PROCS;
    localparam int NL = mlfq_pkg::NUM_LEVELS;
    localparam int PW = mlfq_pkg::PID_W;
    localparam int LW = mlfq_pkg::LVL_W;
    localparam int IW = mlfq_pkg::IDX_W;
    localparam int SW = mlfq_pkg::SLC_W;
    localparam int CW = mlfq_pkg::CHN_W;
    localparam int QW = mlfq_pkg::QADDR_W;
    localparam logic [LW-1:0] LAST = LW'(mlfq_pkg::LAST_LEVEL);
    localparam logic [IW-1:0] FULL = IW'(mlfq_pkg::MAX_PROCS);

    // Control state
    logic [NP-1:0]         used_reg, used_next;
    logic [NP-1:0]         run_reg, run_next;
    logic [NL-1:0][IW-1:0] fill_reg, fill_next;
    logic [LW-1:0]         swl_reg, swl_next;
    logic [IW-1:0]         swp_reg, swp_next;
    logic [IW-1:0]         left_reg, left_next;

    // Work registers
    logic [mlfq_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic [PW-1:0]  pid_reg, pid_next;
    logic [CW-1:0]  tag_reg, tag_next;
    logic [LW-1:0]  lvl_reg, lvl_next;
    logic [LW-1:0]  app_reg, app_next;
    logic [IW-1:0]  idx_reg, idx_next;
    logic [IW-1:0]  scan_reg, scan_next;

    // Result being built
    logic [mlfq_pkg::STS_W-1:0]   rsts_reg, rsts_next;
    logic [PW-1:0]                rid_reg, rid_next;
    logic [LW-1:0]                rlvl_reg, rlvl_next;
    logic [SW-1:0]                rcnt_reg, rcnt_next;
    logic                         rdem_reg, rdem_next;
    logic [mlfq_pkg::WOKEN_W-1:0] rwok_reg, rwok_next;

    // Output word
    logic [mlfq_pkg::STS_W-1:0]   osts_reg;
    logic [PW-1:0]                oid_reg;
    logic [LW-1:0]                olvl_reg;
    logic [SW-1:0]                ocnt_reg;
    logic                         odem_reg;
    logic [mlfq_pkg::WOKEN_W-1:0] owok_reg;

    // RAM ports
    logic          q_we;
    logic [QW-1:0] q_waddr, q_raddr;
    logic [PW-1:0] q_wdata, q_rdata;
    logic          lv_we;
    logic [PW-1:0] lv_waddr, lv_raddr;
    logic [LW-1:0] lv_wdata, lv_rdata;
    logic          sc_we;
    logic [PW-1:0] sc_waddr, sc_raddr;
    logic [SW-1:0] sc_wdata, sc_rdata;
    logic          ch_we;
    logic [PW-1:0] ch_waddr, ch_raddr;
    logic [CW-1:0] ch_wdata, ch_rdata;

    // Derived values
    logic [IW-1:0] cur_fill, sw_fill, idx_p1, idx_m1;
    logic [SW-1:0] cnt_sat, lim_raw, lim_eff;
    logic [IW:0]   sw_span;
    logic          fill_ok;

    mlfq_ram #(.WIDTH(PW), .DEPTH(mlfq_pkg::Q_DEPTH)) u_queue (
        .aclk(aclk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );
    mlfq_ram #(.WIDTH(LW), .DEPTH(NP)) u_level (
        .aclk(aclk), .we(lv_we), .waddr(lv_waddr), .wdata(lv_wdata),
        .raddr(lv_raddr), .rdata(lv_rdata)
    );
    mlfq_ram #(.WIDTH(SW), .DEPTH(NP)) u_slices (
        .aclk(aclk), .we(sc_we), .waddr(sc_waddr), .wdata(sc_wdata),
        .raddr(sc_raddr), .rdata(sc_rdata)
    );
    mlfq_ram #(.WIDTH(CW), .DEPTH(NP)) u_channel (
        .aclk(aclk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
        .raddr(ch_raddr), .rdata(ch_rdata)
    );

    // Fill of the work level and the swept level, saturating slice count
    always_comb begin
        cur_fill = fill_reg[lvl_reg];
        sw_fill  = fill_reg[swl_reg];
        idx_p1   = idx_reg + IW'(1);
        idx_m1   = idx_reg - IW'(1);
        sw_span  = {1'b0, swp_reg} + {1'b0, left_reg};
        cnt_sat  = (sc_rdata == {SW{1'b1}}) ? sc_rdata : sc_rdata + SW'(1);
        case (swl_reg)
            2'd0:    lim_raw = lim0;
            2'd1:    lim_raw = lim1;
            2'd2:    lim_raw = lim2;
            default: lim_raw = SW'(mlfq_pkg::DEEP_LIMIT);
        endcase
        lim_eff = (lim_raw == '0) ? SW'(1) : lim_raw;
        fill_ok = 1'b1;
        for (int l = 0; l < NL; l++) begin
            if (fill_reg[l] > FULL) begin
                fill_ok = 1'b0;
            end
        end
    end

    // Status to the controller
    always_comb begin
        stat.cmd        = cmd_reg;
        stat.any_run    = |(used_reg & run_reg);
        stat.pid_used   = used_reg[pid_reg];
        stat.fill0_full = fill_reg[0] >= FULL;
        stat.sw_last    = swl_reg == LAST;
        stat.sw_end     = (swl_reg == LAST) ? (left_reg == '0 || swp_reg >= sw_fill)
                                            : (swp_reg >= sw_fill);
        stat.q_run      = used_reg[q_rdata] & run_reg[q_rdata];
        stat.demote     = cnt_sat >= lim_eff;
        stat.idx_end    = idx_reg >= cur_fill;
        stat.idx_zero   = idx_reg == '0;
        stat.q_match    = q_rdata == pid_reg;
        stat.scan_end   = scan_reg == FULL;
        stat.wk_match   = used_reg[scan_reg[PW-1:0]] & ~run_reg[scan_reg[PW-1:0]]
                          & (ch_rdata == tag_reg);
    end

    // Execute the op of this cycle
    always_comb begin
        used_next = used_reg;
        run_next  = run_reg;
        fill_next = fill_reg;
        swl_next  = swl_reg;
        swp_next  = swp_reg;
        left_next = left_reg;
        cmd_next  = cmd_reg;
        pid_next  = pid_reg;
        tag_next  = tag_reg;
        lvl_next  = lvl_reg;
        app_next  = app_reg;
        idx_next  = idx_reg;
        scan_next = scan_reg;
        rsts_next = rsts_reg;
        rid_next  = rid_reg;
        rlvl_next = rlvl_reg;
        rcnt_next = rcnt_reg;
        rdem_next = rdem_reg;
        rwok_next = rwok_reg;
        q_we = 1'b0;  q_waddr = '0;  q_wdata = '0;  q_raddr = '0;
        lv_we = 1'b0; lv_waddr = '0; lv_wdata = '0; lv_raddr = '0;
        sc_we = 1'b0; sc_waddr = '0; sc_wdata = '0; sc_raddr = '0;
        ch_we = 1'b0; ch_waddr = '0; ch_wdata = '0; ch_raddr = '0;
        case (op)
            mlfq_pkg::OP_LATCH: begin
                cmd_next  = in_cmd;
                pid_next  = in_pid;
                tag_next  = in_tag;
                scan_next = '0;
                rsts_next = mlfq_pkg::STS_OK;
                rid_next  = '0;
                rlvl_next = '0;
                rcnt_next = '0;
                rdem_next = 1'b0;
                rwok_next = '0;
            end
            mlfq_pkg::OP_RES_IDLE:    rsts_next = mlfq_pkg::STS_IDLE;
            mlfq_pkg::OP_RES_FULL:    rsts_next = mlfq_pkg::STS_FULL;
            mlfq_pkg::OP_RES_UNKNOWN: rsts_next = mlfq_pkg::STS_UNKNOWN;
            mlfq_pkg::OP_ADMIT: begin
                used_next[pid_reg] = 1'b1;
                run_next[pid_reg]  = 1'b1;
                lv_we = 1'b1; lv_waddr = pid_reg;
                sc_we = 1'b1; sc_waddr = pid_reg;
                ch_we = 1'b1; ch_waddr = pid_reg;
                q_we    = 1'b1;
                q_waddr = {LW'(0), fill_reg[0][PW-1:0]};
                q_wdata = pid_reg;
                fill_next[0] = fill_reg[0] + IW'(1);
            end
            mlfq_pkg::OP_SLEEP: begin
                run_next[pid_reg] = 1'b0;
                ch_we = 1'b1; ch_waddr = pid_reg; ch_wdata = tag_reg;
            end
            mlfq_pkg::OP_EXIT_START: begin
                used_next[pid_reg] = 1'b0;
                run_next[pid_reg]  = 1'b0;
                lv_raddr = pid_reg;
            end
            mlfq_pkg::OP_EX_LVL: begin
                lvl_next = lv_rdata;
                idx_next = '0;
            end
            mlfq_pkg::OP_SW_NEXT: begin
                swp_next = '0;
                if (swl_reg != LAST) begin
                    swl_next = swl_reg + LW'(1);
                    if (swl_reg + LW'(1) == LAST) begin
                        left_next = fill_reg[LAST];
                    end
                end else begin
                    swl_next = '0;
                end
            end
            mlfq_pkg::OP_SW_READ: q_raddr = {swl_reg, swp_reg[PW-1:0]};
            mlfq_pkg::OP_SW_SKIP: begin
                swp_next = swp_reg + IW'(1);
                if (swl_reg == LAST) begin
                    left_next = left_reg - IW'(1);
                end
            end
            mlfq_pkg::OP_GRANT_RD: begin
                pid_next = q_rdata;
                sc_raddr = q_rdata;
            end
            mlfq_pkg::OP_GRANT_KEEP: begin
                rid_next  = pid_reg;
                rlvl_next = swl_reg;
                rcnt_next = cnt_sat;
                sc_we = 1'b1; sc_waddr = pid_reg; sc_wdata = cnt_sat;
                swp_next = swp_reg + IW'(1);
            end
            mlfq_pkg::OP_GRANT_DEMOTE: begin
                rid_next  = pid_reg;
                rlvl_next = swl_reg;
                rcnt_next = cnt_sat;
                rdem_next = 1'b1;
                sc_we = 1'b1; sc_waddr = pid_reg;
                lv_we = 1'b1; lv_waddr = pid_reg; lv_wdata = swl_reg + LW'(1);
                lvl_next = swl_reg;
                idx_next = swp_reg;
                app_next = swl_reg + LW'(1);
            end
            mlfq_pkg::OP_GRANT_ROTATE: begin
                rid_next  = pid_reg;
                rlvl_next = swl_reg;
                rcnt_next = cnt_sat;
                sc_we = 1'b1; sc_waddr = pid_reg; sc_wdata = cnt_sat;
                lvl_next = swl_reg;
                idx_next = swp_reg;
                app_next = swl_reg;
            end
            mlfq_pkg::OP_RM_ADJ: begin
                fill_next[lvl_reg] = cur_fill - IW'(1);
                if (lvl_reg == swl_reg) begin
                    if (idx_reg < swp_reg) begin
                        swp_next = swp_reg - IW'(1);
                    end else if (lvl_reg == LAST && {1'b0, idx_reg} < sw_span
                                 && left_reg != '0) begin
                        left_next = left_reg - IW'(1);
                    end
                end
            end
            mlfq_pkg::OP_RM_READ: q_raddr = {lvl_reg, idx_p1[PW-1:0]};
            mlfq_pkg::OP_RM_WRITE: begin
                q_we = 1'b1; q_waddr = {lvl_reg, idx_reg[PW-1:0]}; q_wdata = q_rdata;
                idx_next = idx_p1;
            end
            mlfq_pkg::OP_APPEND: begin
                q_we    = 1'b1;
                q_waddr = {app_reg, fill_reg[app_reg][PW-1:0]};
                q_wdata = pid_reg;
                fill_next[app_reg] = fill_reg[app_reg] + IW'(1);
            end
            mlfq_pkg::OP_FD_READ: q_raddr = {lvl_reg, idx_reg[PW-1:0]};
            mlfq_pkg::OP_FD_MISS: idx_next = idx_p1;
            mlfq_pkg::OP_WK_READ: begin
                ch_raddr = scan_reg[PW-1:0];
                lv_raddr = scan_reg[PW-1:0];
            end
            mlfq_pkg::OP_WK_NEXT: scan_next = scan_reg + IW'(1);
            mlfq_pkg::OP_WK_HIT: begin
                run_next[scan_reg[PW-1:0]] = 1'b1;
                sc_we = 1'b1; sc_waddr = scan_reg[PW-1:0];
                pid_next  = scan_reg[PW-1:0];
                lvl_next  = lv_rdata;
                idx_next  = '0;
                rwok_next = rwok_reg + mlfq_pkg::WOKEN_W'(1);
            end
            mlfq_pkg::OP_INS_ADJ: begin
                fill_next[lvl_reg] = fill_reg[lvl_reg] + IW'(1);
                if (lvl_reg == swl_reg) begin
                    if (swp_reg != '0) begin
                        swp_next = swp_reg + IW'(1);
                    end else if (lvl_reg == LAST) begin
                        left_next = left_reg + IW'(1);
                    end
                end
            end
            mlfq_pkg::OP_MF_READ: q_raddr = {lvl_reg, idx_m1[PW-1:0]};
            mlfq_pkg::OP_MF_WRITE: begin
                q_we = 1'b1; q_waddr = {lvl_reg, idx_reg[PW-1:0]}; q_wdata = q_rdata;
                idx_next = idx_m1;
            end
            mlfq_pkg::OP_MF_PUT: begin
                q_we = 1'b1; q_waddr = {lvl_reg, PW'(0)}; q_wdata = pid_reg;
                scan_next = scan_reg + IW'(1);
            end
            default: begin
            end
        endcase
    end

    // Control state with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
            run_reg  <= '0;
            fill_reg <= '0;
            swl_reg  <= '0;
            swp_reg  <= '0;
            left_reg <= '0;
        end else begin
            used_reg <= used_next;
            run_reg  <= run_next;
            fill_reg <= fill_next;
            swl_reg  <= swl_next;
            swp_reg  <= swp_next;
            left_reg <= left_next;
        end
    end

    // Work and result registers
    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        pid_reg  <= pid_next;
        tag_reg  <= tag_next;
        lvl_reg  <= lvl_next;
        app_reg  <= app_next;
        idx_reg  <= idx_next;
        scan_reg <= scan_next;
        rsts_reg <= rsts_next;
        rid_reg  <= rid_next;
        rlvl_reg <= rlvl_next;
        rcnt_reg <= rcnt_next;
        rdem_reg <= rdem_next;
        rwok_reg <= rwok_next;
        if (op == mlfq_pkg::OP_OUT_LOAD) begin
            osts_reg <= rsts_reg;
            oid_reg  <= rid_reg;
            olvl_reg <= rlvl_reg;
            ocnt_reg <= rcnt_reg;
            odem_reg <= rdem_reg;
            owok_reg <= rwok_reg;
        end
    end

    assign out_status  = osts_reg;
    assign out_id      = oid_reg;
    assign out_level   = olvl_reg;
    assign out_count   = ocnt_reg;
    assign out_demoted = odem_reg;
    assign out_woken   = owok_reg;

`ifndef SYNTHESIS
    // No level ever holds more entries than there are slots
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn) fill_ok)
        else $error("level fill above slot count");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/mlfq_ctrl.sv -----
// Scheduler controller: FSM that sequences datapath ops and owns the
// input and output handshakes. Uses mlfq_pkg.
`default_nettype none

module mlfq_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  wire                 m_tready,
    input  mlfq_pkg::dp_stat_t  stat,
    output mlfq_pkg::dp_op_t    op
);

    mlfq_pkg::state_t state_reg, state_next;
    logic             ovld_reg, ovld_next;

    // State and output-valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mlfq_pkg::S_IDLE;
            ovld_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            ovld_reg  <= ovld_next;
        end
    end

    // Next state and op
    always_comb begin
        state_next = state_reg;
        op         = mlfq_pkg::OP_NONE;
        s_tready   = 1'b0;
        case (state_reg)
            mlfq_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op         = mlfq_pkg::OP_LATCH;
                    state_next = mlfq_pkg::S_DISPATCH;
                end
            end
            mlfq_pkg::S_DISPATCH: begin
                state_next = mlfq_pkg::S_DONE;
                case (stat.cmd)
                    mlfq_pkg::CMD_PICK: begin
                        if (!stat.any_run) begin
                            op = mlfq_pkg::OP_RES_IDLE;
                        end else begin
                            state_next = mlfq_pkg::S_SW_TEST;
                        end
                    end
                    mlfq_pkg::CMD_ADMIT: begin
                        if (stat.pid_used || stat.fill0_full) begin
                            op = mlfq_pkg::OP_RES_FULL;
                        end else begin
                            op = mlfq_pkg::OP_ADMIT;
                        end
                    end
                    mlfq_pkg::CMD_SLEEP: begin
                        op = stat.pid_used ? mlfq_pkg::OP_SLEEP : mlfq_pkg::OP_RES_UNKNOWN;
                    end
                    mlfq_pkg::CMD_WAKE: state_next = mlfq_pkg::S_WK_RD;
                    mlfq_pkg::CMD_EXIT: begin
                        if (stat.pid_used) begin
                            op         = mlfq_pkg::OP_EXIT_START;
                            state_next = mlfq_pkg::S_EX_LVL;
                        end else begin
                            op = mlfq_pkg::OP_RES_UNKNOWN;
                        end
                    end
                    default: state_next = mlfq_pkg::S_DONE;
                endcase
            end
            mlfq_pkg::S_SW_TEST: begin
                if (stat.sw_end) begin
                    op = mlfq_pkg::OP_SW_NEXT;
                end else begin
                    op         = mlfq_pkg::OP_SW_READ;
                    state_next = mlfq_pkg::S_SW_ID;
                end
            end
            mlfq_pkg::S_SW_ID: begin
                if (!stat.q_run) begin
                    op         = mlfq_pkg::OP_SW_SKIP;
                    state_next = mlfq_pkg::S_SW_TEST;
                end else begin
                    op         = mlfq_pkg::OP_GRANT_RD;
                    state_next = mlfq_pkg::S_SW_CNT;
                end
            end
            mlfq_pkg::S_SW_CNT: begin
                if (stat.sw_last) begin
                    op         = mlfq_pkg::OP_GRANT_ROTATE;
                    state_next = mlfq_pkg::S_RM_ADJ;
                end else if (stat.demote) begin
                    op         = mlfq_pkg::OP_GRANT_DEMOTE;
                    state_next = mlfq_pkg::S_RM_ADJ;
                end else begin
                    op         = mlfq_pkg::OP_GRANT_KEEP;
                    state_next = mlfq_pkg::S_DONE;
                end
            end
            mlfq_pkg::S_RM_ADJ: begin
                op         = mlfq_pkg::OP_RM_ADJ;
                state_next = mlfq_pkg::S_RM_RD;
            end
            mlfq_pkg::S_RM_RD: begin
                if (stat.idx_end) begin
                    state_next = (stat.cmd == mlfq_pkg::CMD_PICK) ? mlfq_pkg::S_APPEND
                                                                  : mlfq_pkg::S_DONE;
                end else begin
                    op         = mlfq_pkg::OP_RM_READ;
                    state_next = mlfq_pkg::S_RM_WR;
                end
            end
            mlfq_pkg::S_RM_WR: begin
                op         = mlfq_pkg::OP_RM_WRITE;
                state_next = mlfq_pkg::S_RM_RD;
            end
            mlfq_pkg::S_APPEND: begin
                op         = mlfq_pkg::OP_APPEND;
                state_next = mlfq_pkg::S_DONE;
            end
            mlfq_pkg::S_EX_LVL: begin
                op         = mlfq_pkg::OP_EX_LVL;
                state_next = mlfq_pkg::S_FD_RD;
            end
            mlfq_pkg::S_FD_RD: begin
                if (stat.idx_end) begin
                    state_next = (stat.cmd == mlfq_pkg::CMD_WAKE) ? mlfq_pkg::S_MF_INS
                                                                  : mlfq_pkg::S_DONE;
                end else begin
                    op         = mlfq_pkg::OP_FD_READ;
                    state_next = mlfq_pkg::S_FD_CHK;
                end
            end
            mlfq_pkg::S_FD_CHK: begin
                if (stat.q_match) begin
                    state_next = (stat.cmd == mlfq_pkg::CMD_WAKE) ? mlfq_pkg::S_MF_RM
                                                                  : mlfq_pkg::S_RM_ADJ;
                end else begin
                    op         = mlfq_pkg::OP_FD_MISS;
                    state_next = mlfq_pkg::S_FD_RD;
                end
            end
            mlfq_pkg::S_WK_RD: begin
                if (stat.scan_end) begin
                    state_next = mlfq_pkg::S_DONE;
                end else begin
                    op         = mlfq_pkg::OP_WK_READ;
                    state_next = mlfq_pkg::S_WK_CHK;
                end
            end
            mlfq_pkg::S_WK_CHK: begin
                if (stat.wk_match) begin
                    op         = mlfq_pkg::OP_WK_HIT;
                    state_next = mlfq_pkg::S_FD_RD;
                end else begin
                    op         = mlfq_pkg::OP_WK_NEXT;
                    state_next = mlfq_pkg::S_WK_RD;
                end
            end
            mlfq_pkg::S_MF_RM: begin
                op         = mlfq_pkg::OP_RM_ADJ;
                state_next = mlfq_pkg::S_MF_INS;
            end
            mlfq_pkg::S_MF_INS: begin
                op         = mlfq_pkg::OP_INS_ADJ;
                state_next = mlfq_pkg::S_MF_RD;
            end
            mlfq_pkg::S_MF_RD: begin
                if (stat.idx_zero) begin
                    op         = mlfq_pkg::OP_MF_PUT;
                    state_next = mlfq_pkg::S_WK_RD;
                end else begin
                    op         = mlfq_pkg::OP_MF_READ;
                    state_next = mlfq_pkg::S_MF_WR;
                end
            end
            mlfq_pkg::S_MF_WR: begin
                op         = mlfq_pkg::OP_MF_WRITE;
                state_next = mlfq_pkg::S_MF_RD;
            end
            mlfq_pkg::S_DONE: begin
                if (!ovld_reg || m_tready) begin
                    op         = mlfq_pkg::OP_OUT_LOAD;
                    state_next = mlfq_pkg::S_IDLE;
                end
            end
            default: state_next = mlfq_pkg::S_IDLE;
        endcase
    end

    // Output word valid: set on load, drop when taken
    always_comb begin
        if (op == mlfq_pkg::OP_OUT_LOAD) begin
            ovld_next = 1'b1;
        end else if (m_tready) begin
            ovld_next = 1'b0;
        end else begin
            ovld_next = ovld_reg;
        end
    end

    assign m_tvalid = ovld_reg;

`ifndef SYNTHESIS
    // An accepted word always starts work
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == mlfq_pkg::S_DISPATCH))
        else $error("accepted word did not start work");

    // A finished word with a free output slot is loaded and the FSM returns
    a_done_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mlfq_pkg::S_DONE && (!ovld_reg || m_tready))
        |=> (ovld_reg && state_reg == mlfq_pkg::S_IDLE))
        else $error("finished word not loaded");

    // Output valid rises only out of the done state
    a_valid_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(ovld_reg) |-> $past(state_reg == mlfq_pkg::S_DONE))
        else $error("output valid without finished word");
`endif

endmodule

`default_nettype wire

// ----- verif/mlfq_sched_checker.sv -----
// Checker for the feedback-queue scheduler: snoops the APB port and both
// stream channels, predicts every result word and compares it field by field.
// Depends on mlfq_pkg for sizes, command and status codes.
`timescale 1ns / 1ps

module mlfq_sched_checker (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    input  wire        s_tready,
    input  wire [23:0] s_tdata,
    input  wire        m_tvalid,
    input  wire        m_tready,
    input  wire [23:0] m_tdata,
    input  wire        psel,
    input  wire        penable,
    input  wire        pwrite,
    input  wire [mlfq_pkg::CFG_AW-1:0] paddr,
    input  wire [mlfq_pkg::CFG_DW-1:0] pwdata,
    input  wire        pready,
    output int         mismatches,
    output int         pending,
    output int         words_checked
);

    localparam int NP = mlfq_pkg::MAX_PROCS;
    localparam int NL = mlfq_pkg::NUM_LEVELS;
    localparam int LAST = mlfq_pkg::LAST_LEVEL;

    typedef struct {
        logic [mlfq_pkg::STS_W-1:0]   sts;
        logic [mlfq_pkg::PID_W-1:0]   gid;
        logic [mlfq_pkg::LVL_W-1:0]   glvl;
        logic [mlfq_pkg::SLC_W-1:0]   cnt;
        logic                         dem;
        logic [mlfq_pkg::WOKEN_W-1:0] woken;
    } sched_word_t;

    localparam int SWEEP_MAX = 2 * NL * (NP + 2) + 8;

    // shadow copy of the scheduler state
    logic [mlfq_pkg::PID_W-1:0] queue_mem [NL][NP];
    int               fill [NL];
    int               p_level [NP];
    int               p_slices [NP];
    logic             p_used [NP];
    logic             p_run [NP];
    logic [mlfq_pkg::CHN_W-1:0] p_chan [NP];
    int               sw_lvl, sw_pos, deep_left;
    logic [mlfq_pkg::SLC_W-1:0] limit_reg [3];

    sched_word_t expected_words [$];

    function automatic int limit_of(int lv);
        int v;
        v = (lv < 3) ? int'(limit_reg[lv]) : mlfq_pkg::DEEP_LIMIT;
        return (v == 0) ? 1 : v;
    endfunction

    function automatic bit runnable(int id);
        return p_used[id] && p_run[id];
    endfunction

    function automatic void append_rear(int lv, int id);
        if (fill[lv] >= NP) return;
        queue_mem[lv][fill[lv]] = id[mlfq_pkg::PID_W-1:0];
        fill[lv]++;
    endfunction

    function automatic void insert_front(int lv, int id);
        if (fill[lv] >= NP) return;
        for (int k = fill[lv]; k > 0; k--) queue_mem[lv][k] = queue_mem[lv][k-1];
        queue_mem[lv][0] = id[mlfq_pkg::PID_W-1:0];
        fill[lv]++;
        // keep the sweep pointing at the same entry
        if (lv == sw_lvl) begin
            if (sw_pos > 0) sw_pos++;
            else if (lv == LAST) deep_left++;
        end
    endfunction

    function automatic void remove_at(int lv, int k);
        if (k >= fill[lv]) return;
        for (int j = k; j + 1 < fill[lv]; j++) queue_mem[lv][j] = queue_mem[lv][j+1];
        fill[lv]--;
        // step the sweep back so nothing is skipped
        if (lv == sw_lvl) begin
            if (k < sw_pos) sw_pos--;
            else if (lv == LAST && k < sw_pos + deep_left && deep_left > 0)
                deep_left--;
        end
    endfunction

    function automatic void unlink(int id);
        int lv;
        lv = p_level[id];
        for (int k = 0; k < fill[lv]; k++) begin
            if (queue_mem[lv][k] == id) begin
                remove_at(lv, k);
                return;
            end
        end
    endfunction

    function automatic void pick_next(ref sched_word_t w);
        bit any;
        int lv, id, cnt;
        any = 0;
        for (int p = 0; p < NP; p++) if (runnable(p)) any = 1;
        if (!any) begin
            w.sts = mlfq_pkg::STS_IDLE;
            return;
        end
        for (int it = 0; it < SWEEP_MAX; it++) begin
            lv = sw_lvl;
            if (lv < LAST) begin
                if (sw_pos >= fill[lv]) begin
                    sw_lvl = lv + 1;
                    sw_pos = 0;
                    if (sw_lvl == LAST) deep_left = fill[LAST];
                    continue;
                end
                id = int'(queue_mem[lv][sw_pos]);
                if (!runnable(id)) begin
                    sw_pos++;
                    continue;
                end
                cnt = (p_slices[id] < 15) ? p_slices[id] + 1 : 15;
                w.gid  = mlfq_pkg::PID_W'(id);
                w.glvl = mlfq_pkg::LVL_W'(lv);
                w.cnt  = mlfq_pkg::SLC_W'(cnt);
                if (cnt >= limit_of(lv)) begin
                    // demote one level, count restarts
                    remove_at(lv, sw_pos);
                    append_rear(lv + 1, id);
                    p_level[id] = lv + 1;
                    p_slices[id] = 0;
                    w.dem = 1'b1;
                end else begin
                    p_slices[id] = cnt;
                    sw_pos++;
                end
                return;
            end
            if (deep_left == 0 || sw_pos >= fill[lv]) begin
                sw_lvl = 0;
                sw_pos = 0;
                continue;
            end
            id = int'(queue_mem[lv][sw_pos]);
            if (!runnable(id)) begin
                sw_pos++;
                deep_left--;
                continue;
            end
            // bottom level: rotate to the rear
            cnt = (p_slices[id] < 15) ? p_slices[id] + 1 : 15;
            p_slices[id] = cnt;
            w.gid  = mlfq_pkg::PID_W'(id);
            w.glvl = mlfq_pkg::LVL_W'(lv);
            w.cnt  = mlfq_pkg::SLC_W'(cnt);
            remove_at(lv, sw_pos);
            append_rear(lv, id);
            return;
        end
        w.sts = mlfq_pkg::STS_IDLE;
    endfunction

    function automatic sched_word_t predict_word(logic [23:0] d);
        sched_word_t w;
        logic [mlfq_pkg::CMD_W-1:0] cmd;
        int id, n;
        logic [mlfq_pkg::CHN_W-1:0] tag;
        w = '{default: '0};
        cmd = d[2:0];
        id  = int'(d[8:3]);
        tag = d[16:9];
        case (cmd)
            mlfq_pkg::CMD_PICK: pick_next(w);
            mlfq_pkg::CMD_ADMIT: begin
                if (p_used[id] || fill[0] >= NP) w.sts = mlfq_pkg::STS_FULL;
                else begin
                    p_used[id] = 1; p_run[id] = 1;
                    p_level[id] = 0; p_slices[id] = 0; p_chan[id] = '0;
                    append_rear(0, id);
                end
            end
            mlfq_pkg::CMD_SLEEP: begin
                if (!p_used[id]) w.sts = mlfq_pkg::STS_UNKNOWN;
                else begin
                    p_run[id] = 0;
                    p_chan[id] = tag;
                end
            end
            mlfq_pkg::CMD_WAKE: begin
                n = 0;
                for (int p = 0; p < NP; p++) begin
                    if (p_used[p] && !p_run[p] && p_chan[p] == tag) begin
                        p_run[p] = 1;
                        p_slices[p] = 0;
                        unlink(p);
                        insert_front(p_level[p], p);
                        n++;
                    end
                end
                w.woken = mlfq_pkg::WOKEN_W'(n);
            end
            mlfq_pkg::CMD_EXIT: begin
                if (!p_used[id]) w.sts = mlfq_pkg::STS_UNKNOWN;
                else begin
                    unlink(id);
                    p_used[id] = 0; p_run[id] = 0;
                    p_level[id] = 0; p_slices[id] = 0; p_chan[id] = '0;
                end
            end
            default: ;
        endcase
        return w;
    endfunction

    task automatic report(string what, int got, int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic check_word(logic [23:0] d);
        sched_word_t e;
        if (expected_words.size() == 0) begin
            report("unexpected word", int'(d), 0);
            return;
        end
        e = expected_words.pop_front();
        words_checked++;
        if (d[1:0]   != e.sts)   report("status", int'(d[1:0]), int'(e.sts));
        if (d[7:2]   != e.gid)   report("granted_id", int'(d[7:2]), int'(e.gid));
        if (d[9:8]   != e.glvl)  report("granted_level", int'(d[9:8]), int'(e.glvl));
        if (d[13:10] != e.cnt)   report("slice_count", int'(d[13:10]), int'(e.cnt));
        if (d[14]    != e.dem)   report("demoted", int'(d[14]), int'(e.dem));
        if (d[21:15] != e.woken) report("woken_count", int'(d[21:15]), int'(e.woken));
    endtask

    initial begin
        mismatches = 0;
        words_checked = 0;
    end

    assign pending = expected_words.size();

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int l = 0; l < NL; l++) fill[l] = 0;
            for (int p = 0; p < NP; p++) begin
                p_level[p] = 0; p_slices[p] = 0;
                p_used[p] = 0; p_run[p] = 0; p_chan[p] = '0;
            end
            sw_lvl = 0; sw_pos = 0; deep_left = 0;
            limit_reg[mlfq_pkg::CFG_LIMIT0] = mlfq_pkg::LIMIT0_RST;
            limit_reg[mlfq_pkg::CFG_LIMIT1] = mlfq_pkg::LIMIT1_RST;
            limit_reg[mlfq_pkg::CFG_LIMIT2] = mlfq_pkg::LIMIT2_RST;
            expected_words.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[3:2] <= mlfq_pkg::CFG_LIMIT2)
                limit_reg[paddr[3:2]] = pwdata[mlfq_pkg::SLC_W-1:0];
            // older word leaves before the new one is predicted
            if (m_tvalid && m_tready) check_word(m_tdata);
            if (s_tvalid && s_tready) expected_words.push_back(predict_word(s_tdata));
        end
    end

endmodule

// ----- verif/mlfq_process_scheduler_unit_tb.sv -----
// Testbench top for mlfq_process_scheduler_unit: clock, reset, APB setup,
// directed and random command words with bursty input and stalling output.
// Depends on mlfq_pkg, the RTL and mlfq_sched_checker.
`timescale 1ns / 1ps

module mlfq_process_scheduler_unit_tb;

    localparam longint CYCLE_LIMIT = 100_000_000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // [2:0] cmd, [8:3] proc_id, [16:9] wait_channel, [23:17] zero
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // [1:0] status, [7:2] granted_id, [9:8] granted_level, [13:10] slice_count,
    // [14] demoted, [21:15] woken_count, [23:22] zero
    logic [23:0] m_tdata;
    logic        psel, penable, pwrite;
    logic [mlfq_pkg::CFG_AW-1:0] paddr;
    logic [mlfq_pkg::CFG_DW-1:0] pwdata;
    logic [mlfq_pkg::CFG_DW-1:0] prdata;
    logic        pready;

    int     mismatches, pending, words_checked;
    longint cycles;
    int     words_sent;
    int     burst_left;
    bit     hold_req;

    mlfq_process_scheduler_unit u_top (.*);

    mlfq_sched_checker u_checker (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .mismatches, .pending, .words_checked
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d words outstanding", cycles, pending);
                $display("mlfq_process_scheduler_unit regression: fail");
                $finish;
            end
        end
    end

    // output side: stall pattern changes every stretch, one long hold on request
    initial begin
        int mode, left, hold_cnt;
        bit hold_done;
        m_tready = 1'b0;
        mode = 0;
        left = 0;
        hold_done = 0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                hold_cnt = 0;
                m_tready = 1'b0;
                while (hold_cnt < 400) begin
                    @(negedge aclk);
                    hold_cnt++;
                end
                hold_done = 1;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(16, 120);
            end
            left--;
            case (mode)
                0: m_tready = 1'b1;
                1: m_tready = ($urandom_range(0, 1) == 0);
                2: m_tready = ($urandom_range(0, 4) != 0);
                default: m_tready = ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // offer one word and hold it until taken
    task automatic send_word(logic [mlfq_pkg::CMD_W-1:0] cmd, int id, int tag);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {7'd0, tag[mlfq_pkg::CHN_W-1:0], id[mlfq_pkg::PID_W-1:0], cmd};
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        words_sent++;
        // bursts with random gaps between them
        if (burst_left > 0) burst_left--;
        else begin
            burst_left = $urandom_range(0, 12);
            repeat ($urandom_range(0, 1) ? $urandom_range(1, 6) : 0) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
            end
        end
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_limit(logic [1:0] idx, int val);
        @(negedge aclk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic random_word();
        int r, id, tag;
        logic [mlfq_pkg::CMD_W-1:0] cmd;
        r   = $urandom_range(0, 99);
        id  = $urandom_range(0, 3) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 23);
        tag = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 5);
        if (r < 40)      cmd = mlfq_pkg::CMD_PICK;
        else if (r < 60) cmd = mlfq_pkg::CMD_ADMIT;
        else if (r < 72) cmd = mlfq_pkg::CMD_SLEEP;
        else if (r < 84) cmd = mlfq_pkg::CMD_WAKE;
        else if (r < 95) cmd = mlfq_pkg::CMD_EXIT;
        else             cmd = mlfq_pkg::CMD_W'($urandom_range(5, 7));
        send_word(cmd, id, tag);
    endtask

    initial begin
        int lim [5][3];
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        paddr = '0; pwdata = '0;
        hold_req = 0;
        words_sent = 0;
        burst_left = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: idle pick, extremes, repeats, stray commands
        send_word(mlfq_pkg::CMD_PICK, 0, 0);
        send_word(mlfq_pkg::CMD_ADMIT, 0, 0);
        send_word(mlfq_pkg::CMD_ADMIT, 63, 255);
        send_word(mlfq_pkg::CMD_ADMIT, 0, 0);
        send_word(mlfq_pkg::CMD_EXIT, 5, 0);
        send_word(mlfq_pkg::CMD_SLEEP, 5, 9);
        send_word(mlfq_pkg::CMD_PICK, 0, 0);
        send_word(mlfq_pkg::CMD_PICK, 0, 0);
        send_word(mlfq_pkg::CMD_PICK, 0, 0);
        send_word(mlfq_pkg::CMD_SLEEP, 63, 255);
        send_word(mlfq_pkg::CMD_SLEEP, 63, 0);
        send_word(mlfq_pkg::CMD_WAKE, 0, 77);
        send_word(mlfq_pkg::CMD_SLEEP, 0, 0);
        send_word(mlfq_pkg::CMD_PICK, 0, 0);
        send_word(mlfq_pkg::CMD_WAKE, 0, 0);
        send_word(mlfq_pkg::CMD_PICK, 0, 0);
        send_word(3'd5, 63, 255);
        send_word(3'd6, 0, 0);
        send_word(3'd7, 42, 170);
        send_word(mlfq_pkg::CMD_EXIT, 63, 0);
        send_word(mlfq_pkg::CMD_EXIT, 0, 0);
        send_word(mlfq_pkg::CMD_PICK, 0, 0);
        drain();

        // limit settings per phase: reset values, max, min, zero, random
        lim = '{'{1, 2, 4}, '{15, 15, 15}, '{1, 1, 1}, '{0, 0, 0}, '{3, 7, 11}};
        for (int ph = 0; ph < 5; ph++) begin
            if (ph == 4)
                for (int i = 0; i < 3; i++) lim[ph][i] = $urandom_range(1, 15);
            write_limit(mlfq_pkg::CFG_LIMIT0, lim[ph][0]);
            write_limit(mlfq_pkg::CFG_LIMIT1, lim[ph][1]);
            write_limit(mlfq_pkg::CFG_LIMIT2, lim[ph][2]);
            if (ph == 2) hold_req = 1;
            for (int n = 0; n < 240; n++) random_word();
            drain();
        end

        $display("covered %0d command words, %0d results checked, five slice-limit settings",
                 words_sent, words_checked);
        if (mismatches == 0)
            $display("mlfq_process_scheduler_unit regression: pass");
        else
            $display("mlfq_process_scheduler_unit regression: fail");
        $finish;
    end

endmodule
